// File: hdl/ssfe_pkg.sv
// ---------------------------------------------------------------------------
// ssfe_pkg
// Shared types, widths and table generators for the stereo STFT frame engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ssfe_pkg;

  localparam int unsigned N_POINTS_DEF = 64;

  localparam int HOP_W      = 13;
  localparam int SMP_W      = 16;
  localparam int RES_W      = 32;
  localparam int POW_W      = 63;
  localparam int FNUM_W     = 32;
  localparam int FPOS_W     = 48;
  localparam int BIN_W      = 12;
  localparam int TW_W       = 32;
  localparam int WIN_W      = 17;
  localparam int SQRT_STEPS = 32;

  localparam logic [HOP_W-1:0] HOP_RESET = 13'd32;

  localparam longint ONE_Q30         = 64'sd1 << 30;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam longint ATAN_TURN [30] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
    64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722,
    64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
    64'sd652, 64'sd326, 64'sd163, 64'sd81, 64'sd41, 64'sd20,
    64'sd10, 64'sd5, 64'sd3, 64'sd1
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_MAC,
    ST_RND,
    ST_SQ,
    ST_PW,
    ST_SQRT,
    ST_EMIT
  } ssfe_state_e;

  typedef struct packed {
    logic smp_acc;    // sample word taken
    logic win_rd;     // windowing sweep read
    logic mac_rd;     // bin accumulation read
    logic bin_clr;    // clear accumulators and twiddle phase
    logic rnd;        // round accumulators
    logic sq;         // square real and imag
    logic pw;         // sum power, load root unit
    logic sqrt_step;  // one root digit
    logic frame_done; // last bin taken
  } ssfe_cmd_t;

  typedef struct packed {
    logic fire;       // current sample completes a frame
  } ssfe_sts_t;

  // {cos, sin} in Q2.30 for index m of a 2^log_n point circle
  function automatic logic [63:0] twiddle(input int unsigned m, input int unsigned log_n);
    longint x, y, z, t, c, s;
    logic [63:0] step_m;
    logic [31:0] phase;
    logic [1:0]  quad;
    step_m = 64'(m) << (32 - log_n);
    phase  = step_m[31:0];
    quad   = phase[31:30];
    z      = {34'd0, phase[29:0]};
    x      = CORDIC_GAIN_Q30;
    y      = 0;
    if (z == 0) begin
      x = ONE_Q30;
    end else begin
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - ATAN_TURN[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + ATAN_TURN[i];
        end
        x = t;
      end
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    case (quad)
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    return {c[31:0], s[31:0]};
  endfunction

  // periodic Hann coefficient, Q1.15, 0..32768
  function automatic logic [WIN_W-1:0] window_coef(input logic signed [TW_W-1:0] c);
    longint v;
    v = ONE_Q30 - longint'(c) + 64'sd32768;
    return v[16+WIN_W-1:16];
  endfunction

endpackage

`default_nettype wire

// File: hdl/stereo_stft_frame_engine_core.sv
// ---------------------------------------------------------------------------
// stereo_stft_frame_engine_core
// Stereo Hann-windowed real DFT, one result word per bin 0..N/2 per frame.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  input   | in_valid_i/in_ready_o | left_sample_i, right_sample_i
//  output  | out_valid_o/out_ready_i | frame, bin, re/im/mag/power x2, last
//  config  | cfg_we_i              | cfg_wdata_i (hop length)
//
//  A sample word that completes no frame is taken straight from idle.
//  A frame runs a window sweep, then per bin a MAC pass, rounding,
//  squaring, power and the root digit steps, then waits for out_ready_i.
//  The MAC pass does one MAC per channel per cycle.
//  No sample is taken while a frame is computed or its words wait.
//  Reset needs no clearing pass; the history RAM is only read once full.
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_stft_frame_engine_core #(
  parameter int unsigned N_POINTS = ssfe_pkg::N_POINTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [ssfe_pkg::SMP_W-1:0] left_sample_i,
  input  wire logic signed [ssfe_pkg::SMP_W-1:0] right_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ssfe_pkg::FNUM_W-1:0]            frame_number_o,
  output logic [ssfe_pkg::FPOS_W-1:0]            frame_start_o,
  output logic [ssfe_pkg::BIN_W-1:0]             bin_index_o,
  output logic signed [ssfe_pkg::RES_W-1:0]      left_real_o,
  output logic signed [ssfe_pkg::RES_W-1:0]      left_imag_o,
  output logic [ssfe_pkg::RES_W-1:0]             left_magnitude_o,
  output logic [ssfe_pkg::POW_W-1:0]             left_power_o,
  output logic signed [ssfe_pkg::RES_W-1:0]      right_real_o,
  output logic signed [ssfe_pkg::RES_W-1:0]      right_imag_o,
  output logic [ssfe_pkg::RES_W-1:0]             right_magnitude_o,
  output logic [ssfe_pkg::POW_W-1:0]             right_power_o,
  output logic                                   last_bin_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ssfe_pkg::HOP_W-1:0]        cfg_wdata_i
);

  import ssfe_pkg::*;

  localparam int LOG_N = $clog2(N_POINTS);

  ssfe_cmd_t        cmd;
  ssfe_sts_t        sts;
  logic [LOG_N-1:0] idx;
  logic [LOG_N-1:0] bin;

  ssfe_ctrl #(
    .N_POINTS (N_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .bin_o       (bin),
    .last_bin_o  (last_bin_o)
  );

  ssfe_dpath #(
    .N_POINTS (N_POINTS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .idx_i             (idx),
    .bin_i             (bin),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .left_sample_i     (left_sample_i),
    .right_sample_i    (right_sample_i),
    .frame_number_o    (frame_number_o),
    .frame_start_o     (frame_start_o),
    .left_real_o       (left_real_o),
    .left_imag_o       (left_imag_o),
    .left_magnitude_o  (left_magnitude_o),
    .left_power_o      (left_power_o),
    .right_real_o      (right_real_o),
    .right_imag_o      (right_imag_o),
    .right_magnitude_o (right_magnitude_o),
    .right_power_o     (right_power_o)
  );

  assign bin_index_o = BIN_W'(bin);

endmodule

`default_nettype wire

// File: hdl/ssfe_ram.sv
// ---------------------------------------------------------------------------
// ssfe_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ssfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ssfe_ctrl.sv
// ---------------------------------------------------------------------------
// ssfe_ctrl
// Sequencer: sample intake, window sweep, per-bin MAC, rounding, root, emit.
// ---------------------------------------------------------------------------
`default_nettype none

module ssfe_ctrl #(
  parameter int unsigned N_POINTS = ssfe_pkg::N_POINTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire ssfe_pkg::ssfe_sts_t         sts_i,
  output ssfe_pkg::ssfe_cmd_t              cmd_o,
  output logic [$clog2(N_POINTS)-1:0]      idx_o,
  output logic [$clog2(N_POINTS)-1:0]      bin_o,
  output logic                             last_bin_o
);

  import ssfe_pkg::*;

  localparam int LOG_N = $clog2(N_POINTS);
  localparam int CNT_W = (LOG_N + 1 > 5) ? LOG_N + 1 : 5;

  ssfe_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LOG_N-1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  assign last_bin_o = (k_q == LOG_N'(N_POINTS / 2));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.smp_acc = 1'b1;
          if (sts_i.fire) begin
            state_d = ST_WIN;
            cnt_d   = '0;
          end
        end
      end
      ST_WIN: begin
        // reads issue while cnt_q is below N, then the sweep holds until the read and multiply registers drain
        cmd_o.win_rd = (cnt_q < CNT_W'(N_POINTS));
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(N_POINTS + 1)) begin
          state_d       = ST_MAC;
          cnt_d         = '0;
          k_d           = '0;
          cmd_o.bin_clr = 1'b1;
        end
      end
      ST_MAC: begin
        cmd_o.mac_rd = (cnt_q < CNT_W'(N_POINTS));
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(N_POINTS + 1)) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_PW;
      end
      ST_PW: begin
        cmd_o.pw = 1'b1;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_bin_o) begin
            cmd_o.frame_done = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            k_d           = k_q + 1'b1;
            cnt_d         = '0;
            cmd_o.bin_clr = 1'b1;
            state_d       = ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idx_o = cnt_q[LOG_N-1:0];
  assign bin_o = k_q;

endmodule

`default_nettype wire

// File: hdl/ssfe_dpath.sv
// ---------------------------------------------------------------------------
// ssfe_dpath
// Sample history, Hann windowing, direct DFT MAC, rounding, power and root.
// ---------------------------------------------------------------------------
`default_nettype none

module ssfe_dpath #(
  parameter int unsigned N_POINTS = ssfe_pkg::N_POINTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ssfe_pkg::ssfe_cmd_t            cmd_i,
  output ssfe_pkg::ssfe_sts_t                 sts_o,
  input  wire logic [$clog2(N_POINTS)-1:0]    idx_i,
  input  wire logic [$clog2(N_POINTS)-1:0]    bin_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ssfe_pkg::HOP_W-1:0]     cfg_wdata_i,
  input  wire logic signed [ssfe_pkg::SMP_W-1:0] left_sample_i,
  input  wire logic signed [ssfe_pkg::SMP_W-1:0] right_sample_i,
  output logic [ssfe_pkg::FNUM_W-1:0]         frame_number_o,
  output logic [ssfe_pkg::FPOS_W-1:0]         frame_start_o,
  output logic signed [ssfe_pkg::RES_W-1:0]   left_real_o,
  output logic signed [ssfe_pkg::RES_W-1:0]   left_imag_o,
  output logic [ssfe_pkg::RES_W-1:0]          left_magnitude_o,
  output logic [ssfe_pkg::POW_W-1:0]          left_power_o,
  output logic signed [ssfe_pkg::RES_W-1:0]   right_real_o,
  output logic signed [ssfe_pkg::RES_W-1:0]   right_imag_o,
  output logic [ssfe_pkg::RES_W-1:0]          right_magnitude_o,
  output logic [ssfe_pkg::POW_W-1:0]          right_power_o
);

  import ssfe_pkg::*;

  localparam int LOG_N  = $clog2(N_POINTS);
  localparam int PAIR_W = 2 * SMP_W;
  localparam int WPRD_W = SMP_W + WIN_W + 1;
  localparam int PRD_W  = SMP_W + TW_W;
  localparam int ACC_W  = PRD_W + LOG_N;
  localparam int SQ_W   = 2 * RES_W;
  localparam int RT_W   = SQ_W / 2;
  localparam int REM_W  = RT_W + 2;

  // ---------------- constant tables ----------------
  logic signed [TW_W-1:0] cos_tbl [N_POINTS];
  logic signed [TW_W-1:0] sin_tbl [N_POINTS];
  logic [WIN_W-1:0]       win_tbl [N_POINTS];

  for (genvar m = 0; m < N_POINTS; m++) begin : g_rom
    localparam logic [63:0] TW = twiddle(m, LOG_N);
    assign cos_tbl[m] = TW[63:32];
    assign sin_tbl[m] = TW[31:0];
    assign win_tbl[m] = window_coef(TW[63:32]);
  end

  // ---------------- framing counters ----------------
  logic [HOP_W-1:0]  hop_q, sss_q, sss_inc, hop_eff;
  logic              first_q;
  logic [FNUM_W-1:0] fnum_q;
  logic [FPOS_W-1:0] pos_q, pos_nxt, fstart_q;
  logic [LOG_N-1:0]  oldest_q;

  assign sss_inc    = (sss_q == '1) ? sss_q : sss_q + 1'b1;
  assign hop_eff    = (hop_q == '0) ? HOP_W'(1) : hop_q;
  assign sts_o.fire = first_q ? (sss_inc >= hop_eff) : (sss_inc >= HOP_W'(N_POINTS));
  assign pos_nxt    = pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q    <= HOP_RESET;
      sss_q    <= '0;
      first_q  <= 1'b0;
      fnum_q   <= '0;
      pos_q    <= '0;
      oldest_q <= '0;
      fstart_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hop_q <= cfg_wdata_i;
      end
      if (cmd_i.smp_acc) begin
        pos_q <= pos_nxt;
        if (sts_o.fire) begin
          sss_q    <= '0;
          first_q  <= 1'b1;
          oldest_q <= pos_nxt[LOG_N-1:0];
          fstart_q <= pos_nxt - FPOS_W'(N_POINTS);
        end else begin
          sss_q <= sss_inc;
        end
      end
      if (cmd_i.frame_done) begin
        fnum_q <= fnum_q + 1'b1;
      end
    end
  end

  // ---------------- history ring ----------------
  logic [PAIR_W-1:0] hist_rd;
  logic [LOG_N-1:0]  hist_raddr;

  assign hist_raddr = oldest_q + idx_i;

  ssfe_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (N_POINTS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.smp_acc),
    .waddr_i (pos_q[LOG_N-1:0]),
    .wdata_i ({right_sample_i, left_sample_i}),
    .re_i    (cmd_i.win_rd),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  // ---------------- windowing pipe ----------------
  logic [WIN_W-1:0]         win_q;
  logic                     wv1_q, wv2_q;
  logic [LOG_N-1:0]         wi1_q, wi2_q;
  logic signed [WPRD_W-1:0] wprod_l_q, wprod_r_q, wrnd_l, wrnd_r;
  logic [PAIR_W-1:0]        work_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv1_q <= 1'b0;
      wv2_q <= 1'b0;
    end else begin
      wv1_q <= cmd_i.win_rd;
      wv2_q <= wv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_tbl[idx_i];
    wi1_q     <= idx_i;
    wi2_q     <= wi1_q;
    wprod_l_q <= $signed(hist_rd[SMP_W-1:0]) * $signed({1'b0, win_q});
    wprod_r_q <= $signed(hist_rd[PAIR_W-1:SMP_W]) * $signed({1'b0, win_q});
  end

  assign wrnd_l     = wprod_l_q + WPRD_W'(16384);
  assign wrnd_r     = wprod_r_q + WPRD_W'(16384);
  assign work_wdata = {wrnd_r[15+SMP_W-1:15], wrnd_l[15+SMP_W-1:15]};

  // ---------------- windowed frame store ----------------
  logic [PAIR_W-1:0] work_rd;

  ssfe_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (N_POINTS)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wv2_q),
    .waddr_i (wi2_q),
    .wdata_i (work_wdata),
    .re_i    (cmd_i.mac_rd),
    .raddr_i (idx_i),
    .rdata_o (work_rd)
  );

  // ---------------- bin MAC pipe ----------------
  logic [LOG_N-1:0]        ph_q;
  logic                    mv1_q, mv2_q;
  logic signed [TW_W-1:0]  cos_q, sin_q;
  logic signed [PRD_W-1:0] pcl_q, psl_q, pcr_q, psr_q;
  logic signed [ACC_W-1:0] acc_lr_q, acc_li_q, acc_rr_q, acc_ri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= '0;
      mv1_q <= 1'b0;
      mv2_q <= 1'b0;
    end else begin
      mv1_q <= cmd_i.mac_rd;
      mv2_q <= mv1_q;
      if (cmd_i.bin_clr) begin
        ph_q <= '0;
      end else if (cmd_i.mac_rd) begin
        ph_q <= ph_q + bin_i; // k*n mod N
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_tbl[ph_q];
    sin_q <= sin_tbl[ph_q];
    pcl_q <= $signed(work_rd[SMP_W-1:0]) * cos_q;
    psl_q <= $signed(work_rd[SMP_W-1:0]) * sin_q;
    pcr_q <= $signed(work_rd[PAIR_W-1:SMP_W]) * cos_q;
    psr_q <= $signed(work_rd[PAIR_W-1:SMP_W]) * sin_q;
    if (cmd_i.bin_clr) begin
      acc_lr_q <= '0;
      acc_li_q <= '0;
      acc_rr_q <= '0;
      acc_ri_q <= '0;
    end else if (mv2_q) begin
      acc_lr_q <= acc_lr_q + ACC_W'(pcl_q);
      acc_li_q <= acc_li_q - ACC_W'(psl_q);
      acc_rr_q <= acc_rr_q + ACC_W'(pcr_q);
      acc_ri_q <= acc_ri_q - ACC_W'(psr_q);
    end
  end

  // ---------------- round, square, power, root ----------------
  function automatic logic signed [RES_W-1:0] sat_rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [63:0]      w;
    s = a + ACC_W'(ONE_Q30 >>> 1);
    w = 64'(s >>> 30);
    if (w > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (w < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return w[RES_W-1:0];
    end
  endfunction

  function automatic logic [REM_W+RT_W-1:0] root_step(input logic [REM_W-1:0] rem,
                                                      input logic [RT_W-1:0]  root,
                                                      input logic [1:0]       pair);
    logic [REM_W+1:0] sh, tr;
    sh = {rem, pair};
    tr = {2'b00, root, 2'b01};
    if (sh >= tr) begin
      return {REM_W'(sh - tr), root[RT_W-2:0], 1'b1};
    end else begin
      return {REM_W'(sh), root[RT_W-2:0], 1'b0};
    end
  endfunction

  logic signed [RES_W-1:0] re_l_q, im_l_q, re_r_q, im_r_q;
  logic [SQ_W-1:0]         sq_lr_q, sq_li_q, sq_rr_q, sq_ri_q, pw_l, pw_r;
  logic [POW_W-1:0]        pow_l_q, pow_r_q;
  logic [SQ_W-1:0]         val_l_q, val_r_q;
  logic [REM_W-1:0]        rem_l_q, rem_r_q;
  logic [RT_W-1:0]         rt_l_q, rt_r_q;
  logic [REM_W+RT_W-1:0]   stp_l, stp_r;

  assign pw_l  = sq_lr_q + sq_li_q;
  assign pw_r  = sq_rr_q + sq_ri_q;
  assign stp_l = root_step(rem_l_q, rt_l_q, val_l_q[SQ_W-1:SQ_W-2]);
  assign stp_r = root_step(rem_r_q, rt_r_q, val_r_q[SQ_W-1:SQ_W-2]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      re_l_q <= sat_rnd(acc_lr_q);
      im_l_q <= sat_rnd(acc_li_q);
      re_r_q <= sat_rnd(acc_rr_q);
      im_r_q <= sat_rnd(acc_ri_q);
    end
    if (cmd_i.sq) begin
      sq_lr_q <= re_l_q * re_l_q;
      sq_li_q <= im_l_q * im_l_q;
      sq_rr_q <= re_r_q * re_r_q;
      sq_ri_q <= im_r_q * im_r_q;
    end
    if (cmd_i.pw) begin
      pow_l_q <= pw_l[SQ_W-1] ? '1 : pw_l[POW_W-1:0];
      pow_r_q <= pw_r[SQ_W-1] ? '1 : pw_r[POW_W-1:0];
      val_l_q <= pw_l;
      val_r_q <= pw_r;
      rem_l_q <= '0;
      rem_r_q <= '0;
      rt_l_q  <= '0;
      rt_r_q  <= '0;
    end else if (cmd_i.sqrt_step) begin
      val_l_q <= val_l_q << 2;
      val_r_q <= val_r_q << 2;
      {rem_l_q, rt_l_q} <= stp_l;
      {rem_r_q, rt_r_q} <= stp_r;
    end
  end

  assign frame_number_o    = fnum_q;
  assign frame_start_o     = fstart_q;
  assign left_real_o       = re_l_q;
  assign left_imag_o       = im_l_q;
  assign left_magnitude_o  = rt_l_q;
  assign left_power_o      = pow_l_q;
  assign right_real_o      = re_r_q;
  assign right_imag_o      = im_r_q;
  assign right_magnitude_o = rt_r_q;
  assign right_power_o     = pow_r_q;

endmodule

`default_nettype wire

// File: hdl/ssfe_chk.sv
// ---------------------------------------------------------------------------
// ssfe_chk
// Port-level checks for the frame engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ssfe_chk #(
  parameter int unsigned N_POINTS = ssfe_pkg::N_POINTS_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic                              last_bin_o,
  input wire logic [ssfe_pkg::BIN_W-1:0]        bin_index_o,
  input wire logic [ssfe_pkg::FNUM_W-1:0]       frame_number_o,
  input wire logic signed [ssfe_pkg::RES_W-1:0] left_real_o
);

  import ssfe_pkg::*;

  // no sample intake while a word is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output word pending");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_bin_o) |-> (bin_index_o == BIN_W'(N_POINTS / 2)))
    else $error("last flag on wrong bin");

  // next bin needs a full MAC pass
  a_bin_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_bin_o) |=> !out_valid_o && $stable(frame_number_o))
    else $error("bin emitted too early or frame number moved");

  a_frame_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_bin_o) |=>
      (frame_number_o == $past(frame_number_o) + 1'b1))
    else $error("frame number did not advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(left_real_o))
    else $error("stalled word dropped or changed");

endmodule

bind stereo_stft_frame_engine_core ssfe_chk #(
  .N_POINTS (N_POINTS)
) u_ssfe_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .last_bin_o     (last_bin_o),
  .bin_index_o    (bin_index_o),
  .frame_number_o (frame_number_o),
  .left_real_o    (left_real_o)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo STFT frame engine testbench
// Streams stereo sample words under random idling, predicts every spectral
// bin word with a local Hann/DFT model and checks each output word in order.
// ----------------------------------------------------------------------------

typedef struct {
  logic [31:0] frame_number;
  logic [47:0] frame_start;
  logic [11:0] bin_index;
  logic [31:0] left_real;
  logic [31:0] left_imag;
  logic [31:0] left_magnitude;
  logic [62:0] left_power;
  logic [31:0] right_real;
  logic [31:0] right_imag;
  logic [31:0] right_magnitude;
  logic [62:0] right_power;
  logic        last_bin;
} bin_word_t;

class stft_scoreboard;
  localparam int N = 64;
  localparam longint UNIT = 64'sd1 << 30;

  bin_word_t        spectrum_q[$];
  int               errors;
  logic [12:0]      hop;
  logic signed [15:0] left_ring[N];
  logic signed [15:0] right_ring[N];
  int unsigned      since_frame;
  bit               primed;
  logic [31:0]      frame_cnt;
  logic [47:0]      stream_pos;
  longint           cos_tab[N];
  longint           sin_tab[N];
  longint           hann_tab[N];

  function new();
    longint c, s;
    for (int m = 0; m < N; m++) begin
      rotate(32'((64'd1 << 32) / N * m), c, s);
      cos_tab[m]  = c;
      sin_tab[m]  = s;
      hann_tab[m] = (UNIT - c + 32768) >>> 16;
    end
    hop = 13'd32;
    since_frame = 0;
    primed = 0;
    frame_cnt = '0;
    stream_pos = '0;
    errors = 0;
  endfunction

  // 30-step CORDIC over a turn, quarter turns exact
  function void rotate(input logic [31:0] phase, output longint c, output longint s);
    longint x, y, z, t;
    longint atan_t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    x = 652032874;
    y = 0;
    z = longint'(phase[29:0]);
    if (z == 0) begin
      x = UNIT;
    end else begin
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); z = z - atan_t[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); z = z + atan_t[i];
        end
        x = t;
      end
    end
    if (x > UNIT) x = UNIT;
    if (x < -UNIT) x = -UNIT;
    if (y > UNIT) y = UNIT;
    if (y < -UNIT) y = -UNIT;
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void bin_of(input logic signed [15:0] xs[N], input int k,
                       output logic [31:0] re_o, output logic [31:0] im_o,
                       output logic [31:0] mag_o, output logic [62:0] pw_o);
    longint acc_re, acc_im, re, im;
    longint unsigned pw, r, t;
    acc_re = 0;
    acc_im = 0;
    for (int n = 0; n < N; n++) begin
      acc_re += longint'(xs[n]) * cos_tab[(k * n) % N];
      acc_im -= longint'(xs[n]) * sin_tab[(k * n) % N];
    end
    re = sat32((acc_re + (UNIT >>> 1)) >>> 30);
    im = sat32((acc_im + (UNIT >>> 1)) >>> 30);
    pw = longint'(re * re) + longint'(im * im);
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= pw) r = t;
    end
    re_o = re[31:0];
    im_o = im[31:0];
    mag_o = r[31:0];
    pw_o = pw[63] ? {63{1'b1}} : pw[62:0];
  endfunction

  function void note_sample(input logic signed [15:0] l, input logic signed [15:0] r);
    int unsigned step, oldest;
    logic signed [15:0] lw[N], rw[N];
    bin_word_t b;
    longint p;
    left_ring[stream_pos[5:0]] = l;
    right_ring[stream_pos[5:0]] = r;
    stream_pos = stream_pos + 1;
    if (since_frame < 13'h1FFF) since_frame++;
    step = (hop == 0) ? 1 : hop;
    if (primed ? (since_frame < step) : (since_frame < N)) return;
    oldest = stream_pos[5:0];
    for (int n = 0; n < N; n++) begin
      p = longint'(left_ring[(oldest + n) % N]) * hann_tab[n];
      p = (p + 16384) >>> 15;
      lw[n] = p[15:0];
      p = longint'(right_ring[(oldest + n) % N]) * hann_tab[n];
      p = (p + 16384) >>> 15;
      rw[n] = p[15:0];
    end
    for (int k = 0; k <= N / 2; k++) begin
      b.frame_number = frame_cnt;
      b.frame_start = stream_pos - 48'(N);
      b.bin_index = 12'(k);
      bin_of(lw, k, b.left_real, b.left_imag, b.left_magnitude, b.left_power);
      bin_of(rw, k, b.right_real, b.right_imag, b.right_magnitude, b.right_power);
      b.last_bin = (k == N / 2);
      spectrum_q.insert(spectrum_q.size(), b);
    end
    frame_cnt++;
    since_frame = 0;
    primed = 1;
  endfunction

  function void cmp(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endfunction

  function void check_bin(input bin_word_t a);
    bin_word_t e;
    if (spectrum_q.size() == 0) begin
      $error("bin word with nothing expected (bin %0d)", a.bin_index);
      errors++;
      return;
    end
    e = spectrum_q[0];
    spectrum_q.delete(0);
    cmp("frame_number", 64'(e.frame_number), 64'(a.frame_number));
    cmp("frame_start", 64'(e.frame_start), 64'(a.frame_start));
    cmp("bin_index", 64'(e.bin_index), 64'(a.bin_index));
    cmp("left_real", 64'(e.left_real), 64'(a.left_real));
    cmp("left_imag", 64'(e.left_imag), 64'(a.left_imag));
    cmp("left_magnitude", 64'(e.left_magnitude), 64'(a.left_magnitude));
    cmp("left_power", 64'(e.left_power), 64'(a.left_power));
    cmp("right_real", 64'(e.right_real), 64'(a.right_real));
    cmp("right_imag", 64'(e.right_imag), 64'(a.right_imag));
    cmp("right_magnitude", 64'(e.right_magnitude), 64'(a.right_magnitude));
    cmp("right_power", 64'(e.right_power), 64'(a.right_power));
    cmp("last_bin", 64'(e.last_bin), 64'(a.last_bin));
  endfunction
endclass

module testbench;
  import ssfe_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SMP_W-1:0] left_sample_i = '0;
  logic signed [SMP_W-1:0] right_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [FNUM_W-1:0] frame_number_o;
  logic [FPOS_W-1:0] frame_start_o;
  logic [BIN_W-1:0] bin_index_o;
  logic signed [RES_W-1:0] left_real_o, left_imag_o, right_real_o, right_imag_o;
  logic [RES_W-1:0] left_magnitude_o, right_magnitude_o;
  logic [POW_W-1:0] left_power_o, right_power_o;
  logic last_bin_o;
  logic cfg_we_i = 1'b0;
  logic [HOP_W-1:0] cfg_wdata_i = '0;

  stft_scoreboard sb = new();
  int sender_idle_pct = 11;
  int sink_idle_pct = 77;
  int sink_hold = 0;
  int cycles = 0;

  stereo_stft_frame_engine_core u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: ready pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    bin_word_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.frame_number = frame_number_o;
      a.frame_start = frame_start_o;
      a.bin_index = bin_index_o;
      a.left_real = left_real_o;
      a.left_imag = left_imag_o;
      a.left_magnitude = left_magnitude_o;
      a.left_power = left_power_o;
      a.right_real = right_real_o;
      a.right_imag = right_imag_o;
      a.right_magnitude = right_magnitude_o;
      a.right_power = right_power_o;
      a.last_bin = last_bin_o;
      sb.check_bin(a);
    end
  end

  task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    left_sample_i = l;
    right_sample_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(l, r);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] extremes[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    if ($urandom_range(7) == 0) return extremes[$urandom_range(3)];
    if ($urandom_range(3) == 0) return 16'($urandom_range(2047)) - 16'd1024;
    return 16'($urandom);
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_word(pick_sample(), pick_sample());
  endtask

  // block is idle once nothing is owed and trailing sample words settled
  task automatic drain();
    while (sb.spectrum_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_hop(input logic [12:0] h);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = h;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.hop = h;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, both signs, full-scale swings
    send_word(16'sh7FFF, -16'sd32768);
    send_word(-16'sd32768, 16'sh7FFF);
    send_word(16'sd0, 16'sd0);
    send_word(-16'sd1, 16'sd1);
    send_word(16'sh5555, 16'shAAAA);
    send_word(16'shAAAA, 16'sh5555);
    for (int i = 0; i < 19; i++)
      send_word((i % 2) ? 16'sh7FFF : -16'sd32768, (i % 3) ? -16'sd32768 : 16'sh7FFF);
    send_random(75);

    // hop of zero behaves as one, then a true hop of one
    set_hop(13'd0);
    send_random(5);
    set_hop(13'd1);
    send_random(4);

    sender_idle_pct = 77;
    sink_idle_pct = 11;
    set_hop(13'd64);
    send_random(80);
    set_hop(13'h1FFF);
    send_random(20);
    // count already past the new hop: frame on the very next word
    set_hop(13'd5);
    send_random(30);

    sender_idle_pct = 0;
    sink_idle_pct = 0;
    set_hop(13'd20);
    sink_hold = 12000;
    send_random(45);
    drain();
    send_random(20);
    set_hop(13'd4096);
    send_random(25);

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
